// File: design/ogr_pkg.sv
// ----------------------------------------------------------------------------
// ogr_pkg
// Shared types and constants for the outlined glyph row rasterizer.
// ----------------------------------------------------------------------------
package ogr_pkg;

  localparam int MAX_GLYPH_WIDTH  = 15;
  localparam int MAX_GLYPH_HEIGHT = 32;

  localparam logic [31:0] OUTLINE_BLACK     = 32'hff00_0000;
  localparam logic [5:0]  FONT_HEIGHT_RESET = 6'd8;
  localparam logic [5:0]  HEIGHT_CAP        = 6'(MAX_GLYPH_HEIGHT);

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_YROW,
    SEQ_SCAN,
    SEQ_YBOT,
    SEQ_BOTTOM,
    SEQ_FLUSH
  } seq_state_t;

  // sub-step within one column of the scan
  typedef enum logic [1:0] {
    SLOT_LEFT,
    SLOT_MID,
    SLOT_RIGHT
  } slot_t;

  typedef struct packed {
    logic [11:0] a;
    logic [11:0] b;
  } alu_op_t;

  // sequencer -> output stage
  typedef struct packed {
    logic        emit;
    logic        flush;
    logic [11:0] x;
    logic [10:0] y;
    logic [31:0] color;
  } pix_req_t;

  // output stage -> sequencer
  typedef struct packed {
    logic stall;
    logic flush_done;
  } pix_stat_t;

endpackage

// File: design/ogr_in_if.sv
// ----------------------------------------------------------------------------
// ogr_in_if
// Glyph row channel: one word per bitmap row.
// ----------------------------------------------------------------------------
interface ogr_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] origin_x;
  logic [10:0] origin_y;
  logic [4:0]  row_index;
  logic [3:0]  glyph_width;
  logic [15:0] row_bits;
  logic [15:0] above_bits;
  logic [15:0] below_bits;
  logic [31:0] text_color;

  modport source (
    output valid, origin_x, origin_y, row_index, glyph_width,
           row_bits, above_bits, below_bits, text_color,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, row_index, glyph_width,
           row_bits, above_bits, below_bits, text_color,
    output ready
  );
endinterface

// File: design/ogr_out_if.sv
// ----------------------------------------------------------------------------
// ogr_out_if
// Pixel write channel: one word per pixel.
// ----------------------------------------------------------------------------
interface ogr_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] pixel_x;
  logic [10:0]        pixel_y;
  logic [31:0]        pixel_color;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

// File: design/ogr_cfg_if.sv
// ----------------------------------------------------------------------------
// ogr_cfg_if
// Configuration write channel for the font height register.
// ----------------------------------------------------------------------------
interface ogr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] font_height;

  modport source (output valid, font_height, input ready);
  modport sink (input valid, font_height, output ready);
endinterface

// File: design/ogr_coord_alu.sv
// ----------------------------------------------------------------------------
// ogr_coord_alu
// Shared 12-bit coordinate adder, used for row and column positions.
// ----------------------------------------------------------------------------
module ogr_coord_alu (
  input  ogr_pkg::alu_op_t op,
  output logic [11:0]      sum
);
  import ogr_pkg::*;

  assign sum = op.a + op.b;

endmodule

// File: design/ogr_seq.sv
// ----------------------------------------------------------------------------
// ogr_seq
// Column sequencer: one slot per cycle unless stalled; requests pixel words.
// ----------------------------------------------------------------------------
module ogr_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [10:0]         origin_x,
  input  logic [10:0]         origin_y,
  input  logic [4:0]          row_index,
  input  logic [3:0]          glyph_width,
  input  logic [15:0]         row_bits,
  input  logic [15:0]         above_bits,
  input  logic [15:0]         below_bits,
  input  logic [31:0]         text_color,
  input  logic [5:0]          font_height,
  output ogr_pkg::alu_op_t    alu_op,
  input  logic [11:0]         alu_sum,
  output ogr_pkg::pix_req_t   req,
  input  ogr_pkg::pix_stat_t  stat
);
  import ogr_pkg::*;

  seq_state_t  state, state_next;
  slot_t       slot;
  logic [10:0] ox, oy, y_pix;
  logic [4:0]  row;
  logic [3:0]  w, col_s, col_j;
  logic [15:0] cur, above, below;
  logic [31:0] color;
  logic [5:0]  h;
  logic        is_last, inner;

  logic [16:0] cur_ext;
  logic        bit_set, bit_nb, bit_ab;
  logic [5:0]  row_p1;
  logic        row_skip, row_is_last;
  logic [11:0] j12;
  logic        col_end;

  assign cur_ext     = {1'b0, cur};
  assign bit_set     = cur_ext[{1'b0, col_s}];
  assign bit_nb      = cur_ext[5'(col_s) + 5'd1];
  assign bit_ab      = above[col_s] | below[col_s];
  assign row_p1      = {1'b0, row} + 6'd1;
  assign row_is_last = (row_p1 == h);
  assign row_skip    = ({1'b0, row} >= h) || (w == 4'd0);
  assign j12         = {8'd0, col_j};
  assign col_end     = (col_s == 4'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:   if (in_valid) state_next = SEQ_YROW;
      SEQ_YROW:   state_next = row_skip ? SEQ_FLUSH : SEQ_SCAN;
      SEQ_SCAN: begin
        if (!stat.stall && slot == SLOT_RIGHT && col_end)
          state_next = is_last ? SEQ_YBOT : SEQ_FLUSH;
      end
      SEQ_YBOT:   state_next = SEQ_BOTTOM;
      SEQ_BOTTOM: if (!stat.stall && col_end) state_next = SEQ_FLUSH;
      SEQ_FLUSH:  if (stat.flush_done) state_next = SEQ_IDLE;
      default:    state_next = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    alu_op.a  = {1'b0, ox};
    alu_op.b  = j12;
    req.emit  = 1'b0;
    req.flush = 1'b0;
    req.x     = alu_sum;
    req.y     = y_pix;
    req.color = OUTLINE_BLACK;
    case (state)
      SEQ_IDLE: in_ready = 1'b1;
      SEQ_YROW: begin
        alu_op.a = {1'b0, oy};
        alu_op.b = {7'd0, row};
      end
      SEQ_SCAN: begin
        case (slot)
          SLOT_LEFT: begin
            alu_op.b = j12 - 12'd1;
            req.emit = bit_set && (col_j == 4'd0 || !bit_nb);
          end
          SLOT_MID: begin
            req.emit = bit_set || (inner && bit_ab);
            if (bit_set) req.color = color;
          end
          SLOT_RIGHT: begin
            alu_op.b = j12 + 12'd1;
            req.emit = bit_set;
          end
          default: req.emit = 1'b0;
        endcase
      end
      SEQ_YBOT: begin
        alu_op.a = {1'b0, oy};
        alu_op.b = {6'd0, h};
      end
      SEQ_BOTTOM: req.emit = bit_set;
      SEQ_FLUSH:  req.flush = 1'b1;
      default:    req.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SEQ_IDLE: begin
        if (in_valid) begin
          ox    <= origin_x;
          oy    <= origin_y;
          row   <= row_index;
          w     <= glyph_width;
          cur   <= row_bits;
          above <= above_bits;
          below <= below_bits;
          color <= text_color;
          h     <= (font_height > HEIGHT_CAP) ? HEIGHT_CAP : font_height;
        end
      end
      SEQ_YROW: begin
        y_pix   <= alu_sum[10:0];
        is_last <= row_is_last;
        inner   <= (row != 5'd0) && !row_is_last;
        col_s   <= w;
        col_j   <= 4'd0;
        slot    <= SLOT_LEFT;
      end
      SEQ_SCAN: begin
        if (!stat.stall) begin
          case (slot)
            SLOT_LEFT: slot <= SLOT_MID;
            SLOT_MID:  slot <= SLOT_RIGHT;
            default: begin
              slot  <= SLOT_LEFT;
              col_s <= col_s - 4'd1;
              col_j <= col_j + 4'd1;
            end
          endcase
        end
      end
      SEQ_YBOT: begin
        y_pix <= alu_sum[10:0];
        col_s <= w;
        col_j <= 4'd0;
      end
      SEQ_BOTTOM: begin
        if (!stat.stall) begin
          col_s <= col_s - 4'd1;
          col_j <= col_j + 4'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/ogr_out_stage.sv
// ----------------------------------------------------------------------------
// ogr_out_stage
// Pending word plus output register; the pending word learns its last flag
// from whether another request follows before the flush.
// ----------------------------------------------------------------------------
module ogr_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  ogr_pkg::pix_req_t   req,
  output ogr_pkg::pix_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [11:0]  pixel_x,
  output logic [10:0]         pixel_y,
  output logic [31:0]         pixel_color,
  output logic                last
);
  import ogr_pkg::*;

  logic        pend_valid;
  logic [11:0] pend_x;
  logic [10:0] pend_y;
  logic [31:0] pend_color;
  logic        out_load;
  logic        take_new, push_mid, push_last;

  assign out_load  = !out_valid || out_ready;
  assign stat.stall      = req.emit && pend_valid && !out_load;
  assign stat.flush_done = req.flush && (!pend_valid || out_load);
  assign take_new  = req.emit && !stat.stall;
  assign push_mid  = take_new && pend_valid;
  assign push_last = req.flush && pend_valid && out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (push_mid || push_last) out_valid <= 1'b1;
      if (take_new) pend_valid <= 1'b1;
      else if (push_last) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      pend_x     <= req.x;
      pend_y     <= req.y;
      pend_color <= req.color;
    end
    if (push_mid || push_last) begin
      pixel_x     <= pend_x;
      pixel_y     <= pend_y;
      pixel_color <= pend_color;
      last        <= push_last;
    end
  end

endmodule

// File: design/outlined_glyph_row_raster.sv
// ----------------------------------------------------------------------------
// outlined_glyph_row_raster
// Rasterizes one bitmap glyph row with a black outline into pixel writes.
// ----------------------------------------------------------------------------
// The first pixel word reaches the port through the pending word and the output
//   register, moved up by the next request or by the flush.
// Throughput: one column slot per cycle through one adder, while no output
//   stall holds the sequencer; the last row also scans the bottom outline row.
// Output stalls hold the sequencer; the row port is ready only when idle.
// Reset (rst, synchronous): sequencer idle, no words held, font_height = 8.
module outlined_glyph_row_raster (
  input  logic       clk,
  input  logic       rst,
  ogr_cfg_if.sink    cfg,
  ogr_in_if.sink     glyph_in,
  ogr_out_if.source  pixel_out
);
  import ogr_pkg::*;

  logic [5:0] font_height;
  alu_op_t    alu_op;
  logic [11:0] alu_sum;
  pix_req_t   req;
  pix_stat_t  stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_height <= FONT_HEIGHT_RESET;
    end else if (cfg.valid) begin
      font_height <= cfg.font_height;
    end
  end

  ogr_coord_alu u_alu (
    .op  (alu_op),
    .sum (alu_sum)
  );

  ogr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (glyph_in.valid),
    .in_ready    (glyph_in.ready),
    .origin_x    (glyph_in.origin_x),
    .origin_y    (glyph_in.origin_y),
    .row_index   (glyph_in.row_index),
    .glyph_width (glyph_in.glyph_width),
    .row_bits    (glyph_in.row_bits),
    .above_bits  (glyph_in.above_bits),
    .below_bits  (glyph_in.below_bits),
    .text_color  (glyph_in.text_color),
    .font_height (font_height),
    .alu_op      (alu_op),
    .alu_sum     (alu_sum),
    .req         (req),
    .stat        (stat)
  );

  ogr_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .stat        (stat),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .pixel_x     (pixel_out.pixel_x),
    .pixel_y     (pixel_out.pixel_y),
    .pixel_color (pixel_out.pixel_color),
    .last        (pixel_out.last)
  );

endmodule

// File: design/ogr_checker.sv
// ----------------------------------------------------------------------------
// ogr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module ogr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [11:0] pixel_x,
  input  logic [10:0] pixel_y,
  input  logic [31:0] pixel_color,
  input  logic        last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(last))
    else $error("pixel word changed while stalled");

  // one row at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("row port ready right after accepting a row");

  // more words of the row still to come, unless the final word just moved up
  a_busy_mid_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready || (out_valid && last))
    else $error("row port ready before the last word of the row");

  // when idle, only the final word of a row may still be held
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || last)
    else $error("idle with a non-final word held");

endmodule

bind outlined_glyph_row_raster ogr_checker u_ogr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (glyph_in.valid),
  .in_ready    (glyph_in.ready),
  .out_valid   (pixel_out.valid),
  .out_ready   (pixel_out.ready),
  .pixel_x     (pixel_out.pixel_x),
  .pixel_y     (pixel_out.pixel_y),
  .pixel_color (pixel_out.pixel_color),
  .last        (pixel_out.last)
);
